// ----- hw/rtl/hsfd_pkg.sv -----
// hsfd_pkg: shared types and constants for the header sync frame deframer.
// No dependencies; imported by every hsfd module and the top level.
package hsfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;

    // frame layout offsets, counted from the header byte
    localparam int KEY_OFS     = 6;
    localparam int MARK1_OFS   = 14;
    localparam int MARK2_OFS   = 15;
    localparam int PAYLOAD_OFS = 16;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [IDX_W-1:0]     word_idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_HEADER_BYTE   = 2'd0;
    localparam cfg_idx_t CFG_MARKER_FIRST  = 2'd1;
    localparam cfg_idx_t CFG_MARKER_SECOND = 2'd2;

    localparam byte_t HEADER_BYTE_RST   = 8'hAA;
    localparam byte_t MARKER_FIRST_RST  = 8'h10;
    localparam byte_t MARKER_SECOND_RST = 8'h01;

endpackage

// ----- hw/rtl/hsfd_cell.sv -----
// hsfd_cell: one byte cell of the receive window shift line.
// Depends on hsfd_pkg for byte_t.
module hsfd_cell
    import hsfd_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  byte_t din,
    output byte_t dout
);

    byte_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

// ----- hw/rtl/hsfd_drain.sv -----
// hsfd_drain: holds the descrambled words of one frame and hands them out
// one per transaction as a shifting chain of word registers.
// Depends on hsfd_pkg.
module hsfd_drain
    import hsfd_pkg::*;
#(
    parameter int NUM_WORDS = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  word_t     load_words [NUM_WORDS],
    input  logic      out_ready,
    output logic      out_valid,
    output word_idx_t word_index,
    output word_t     word_value,
    output logic      last_word,
    output logic      busy
);

    localparam int LEFT_W = $clog2(NUM_WORDS + 1);
    localparam logic [LEFT_W-1:0] LEFT_FULL = LEFT_W'(NUM_WORDS);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    word_t             word_reg [NUM_WORDS];
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] left_next;
    word_idx_t         idx_reg;
    word_idx_t         idx_next;
    logic              out_fire;

    assign out_valid  = (left_reg != '0);
    assign out_fire   = out_valid && out_ready;
    assign busy       = out_valid;
    assign word_value = word_reg[0];
    assign word_index = idx_reg;
    assign last_word  = (left_reg == LEFT_ONE);

    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            left_next = LEFT_FULL;
            idx_next  = '0;
        end
        else if (out_fire)
        begin
            left_next = left_reg - LEFT_ONE;
            idx_next  = idx_reg + word_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                word_reg[i] <= load_words[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < NUM_WORDS - 1; i++)
            begin
                word_reg[i] <= word_reg[i + 1];
            end
        end
    end

    // a new frame never lands on words still waiting
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy)
        else $error("frame loaded while words pending");

    // the flagged word is always the final index
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_word) |-> (word_index == word_idx_t'(NUM_WORDS - 1)))
        else $error("last word at wrong index");

    // after a load the full frame follows, starting at index zero
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid && word_index == '0 && left_reg == LEFT_FULL))
        else $error("drain did not start a fresh frame");

endmodule

// ----- hw/rtl/header_sync_frame_deframer_top.sv -----
// header_sync_frame_deframer_top: frame hunt over a byte window, word output.
// Depends on hsfd_pkg, hsfd_cell and hsfd_drain.
//
// Usage:
//   Input channel in_valid/in_ready carries one received byte (rx_byte) per
//   transaction. The window is a line of FRAME_LEN byte cells; each accepted
//   byte shifts in at the far end. Once FRAME_LEN bytes are held, every byte
//   checks header and marker bytes of the window it completes.
//   On a match the NUM_WORDS descrambled words are loaded into the word chain
//   at the same edge, and the window count drops to empty.
//   Output channel out_valid/out_ready gives word_index, word_value and
//   last_word, one word per transaction.
//   Latency: first word is valid in the cycle after the completing byte is
//   accepted; words follow one per cycle while out_ready is high.
//   Throughput: one byte per cycle, set by the per-byte shift of the
//   cell line. A byte that could complete a frame is held off (in_ready low)
//   only while words of the previous frame are still waiting in the chain.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once.
//   Reset: window count empty, word chain empty, registers to defaults.
module header_sync_frame_deframer_top
    import hsfd_pkg::*;
#(
    parameter int FRAME_LEN = 58,
    parameter int NUM_WORDS = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  byte_t     cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  byte_t     rx_byte,
    output logic      out_valid,
    input  logic      out_ready,
    output word_idx_t word_index,
    output word_t     word_value,
    output logic      last_word
);

    localparam int CNT_W = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    byte_t            header_reg;
    byte_t            marker1_reg;
    byte_t            marker2_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    byte_t win_q    [FRAME_LEN];
    byte_t win_next [FRAME_LEN];
    word_t frame_words [NUM_WORDS];
    byte_t key;
    logic  in_fire;
    logic  window_full;
    logic  match;
    logic  drain_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_BYTE_RST;
            marker1_reg <= MARKER_FIRST_RST;
            marker2_reg <= MARKER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_BYTE:   header_reg  <= cfg_data;
                CFG_MARKER_FIRST:  marker1_reg <= cfg_data;
                CFG_MARKER_SECOND: marker2_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // window line: oldest byte at cell 0, new byte enters the last cell
    genvar gi;
    generate
        for (gi = 0; gi < FRAME_LEN; gi++)
        begin : g_win
            if (gi == FRAME_LEN - 1)
            begin : g_tail
                assign win_next[gi] = rx_byte;
            end
            else
            begin : g_body
                assign win_next[gi] = win_q[gi + 1];
            end

            hsfd_cell u_cell (
                .clk      (clk),
                .shift_en (in_fire),
                .din      (win_next[gi]),
                .dout     (win_q[gi])
            );
        end
    endgenerate

    // match is judged on the window as it stands after this byte
    assign window_full = (fill_reg == LAST_POS);
    assign key         = win_next[KEY_OFS];
    assign match       = window_full
                      && (win_next[0] == header_reg)
                      && (win_next[MARK1_OFS] == marker1_reg)
                      && (win_next[MARK2_OFS] == marker2_reg);

    genvar gk, gj;
    generate
        for (gk = 0; gk < NUM_WORDS; gk++)
        begin : g_word
            for (gj = 0; gj < 4; gj++)
            begin : g_byte
                localparam int OFS = PAYLOAD_OFS + 4 * gk + gj;
                if (OFS < FRAME_LEN)
                begin : g_in
                    assign frame_words[gk][BYTE_W*gj +: BYTE_W] = win_next[OFS] ^ key;
                end
                else
                begin : g_past
                    // bytes past the frame end read as zero before the key is applied
                    assign frame_words[gk][BYTE_W*gj +: BYTE_W] = key;
                end
            end
        end
    endgenerate

    assign in_ready = !(window_full && drain_busy);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (in_fire)
        begin
            if (!window_full)
            begin
                fill_next = fill_reg + CNT_ONE;
            end
            else if (match)
            begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    hsfd_drain #(
        .NUM_WORDS (NUM_WORDS)
    ) u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire && match),
        .load_words (frame_words),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .word_index (word_index),
        .word_value (word_value),
        .last_word  (last_word),
        .busy       (drain_busy)
    );

    // a matched frame shows its first word on the next cycle
    a_match_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && match) |=> (out_valid && word_index == '0))
        else $error("matched frame produced no output");

    // a match always empties the window
    a_match_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && match) |=> (fill_reg == '0))
        else $error("window not emptied after frame");

    // the input is only held off by pending words at a full window
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (drain_busy && fill_reg == LAST_POS))
        else $error("input stalled without cause");

    // fill count stays inside the window
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_POS)
        else $error("fill count out of range");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for header_sync_frame_deframer_top.
// Depends on hsfd_pkg and the deframer RTL; predicts payload words from a
// byte-window model and checks every word transaction on the output side.
module tb_top;
    import hsfd_pkg::*;

    localparam int FRAME_LEN   = 58;
    localparam int NUM_WORDS   = 10;
    localparam int SETTLE      = 4;
    localparam int WATCHDOG    = 2000;
    localparam int RAND_BYTES  = 130;
    localparam int RAND_WORDS  = 10;
    localparam int PHASE_BYTES = 40;
    localparam int CALM_AFTER  = 90;

    // index past the register map; writes there must be ignored
    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    typedef struct {
        word_idx_t idx;
        word_t     value;
        logic      last;
    } frame_word_t;

    class deframe_tracker;
        byte_t       window[FRAME_LEN];
        int          fill;
        byte_t       hdr;
        byte_t       mk1;
        byte_t       mk2;
        frame_word_t due[$];
        int          mismatches;
        int          words_predicted;

        function new();
            hdr = HEADER_BYTE_RST;
            mk1 = MARKER_FIRST_RST;
            mk2 = MARKER_SECOND_RST;
            fill = 0;
            mismatches = 0;
            words_predicted = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, byte_t v);
            case (idx)
                CFG_HEADER_BYTE:   hdr = v;
                CFG_MARKER_FIRST:  mk1 = v;
                CFG_MARKER_SECOND: mk2 = v;
                default: ;
            endcase
        endfunction

        function void absorb_byte(byte_t b);
            byte_t       key;
            byte_t       pb;
            word_t       w;
            frame_word_t e;
            int          pos;
            if (fill < FRAME_LEN)
            begin
                window[fill] = b;
                fill++;
            end
            if (fill < FRAME_LEN)
                return;
            if (window[0] == hdr && window[MARK1_OFS] == mk1 && window[MARK2_OFS] == mk2)
            begin
                key = window[KEY_OFS];
                for (int k = 0; k < NUM_WORDS; k++)
                begin
                    w = '0;
                    for (int j = 0; j < 4; j++)
                    begin
                        pos = PAYLOAD_OFS + 4 * k + j;
                        pb = (pos < FRAME_LEN) ? window[pos] : 8'h00;
                        w[8*j +: 8] = pb ^ key;
                    end
                    e.idx = word_idx_t'(k);
                    e.value = w;
                    e.last = (k == NUM_WORDS - 1);
                    due.push_back(e);
                    words_predicted++;
                end
                fill = 0;
            end
            else
            begin
                for (int i = 0; i < FRAME_LEN - 1; i++)
                    window[i] = window[i + 1];
                fill = FRAME_LEN - 1;
            end
        endfunction

        function void check_word(word_idx_t idx, word_t value, logic last);
            frame_word_t e;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected word: index %0d value %h last %0b",
                         $time, idx, value, last);
                mismatches++;
                return;
            end
            e = due.pop_front();
            if (idx !== e.idx)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time, e.idx, idx);
                mismatches++;
            end
            if (value !== e.value)
            begin
                $display("%0t: word_value expected %h actual %h", $time, e.value, value);
                mismatches++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last_word expected %0b actual %0b", $time, e.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    byte_t     cfg_data;
    logic      in_valid;
    logic      in_ready;
    byte_t     rx_byte;
    logic      out_valid;
    logic      out_ready;
    word_idx_t word_index;
    word_t     word_value;
    logic      last_word;

    deframe_tracker tracker;
    int             bytes_sent;
    int             idle_cycles = 0;
    int             gap_pct;
    bit             calm;
    byte_t          cur_h;
    byte_t          cur_m1;
    byte_t          cur_m2;

    header_sync_frame_deframer_top #(
        .FRAME_LEN(FRAME_LEN),
        .NUM_WORDS(NUM_WORDS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .word_index(word_index),
        .word_value(word_value),
        .last_word(last_word)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // output side: word checks and the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_word(word_index, word_value, last_word);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // receiver stalls in random bursts until the calm tail of the run
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic idle_in(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_byte(byte_t b);
        if (!calm && $urandom_range(0, 99) < gap_pct)
            idle_in($urandom_range(1, 13));
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.absorb_byte(b);
        bytes_sent++;
    endtask

    // hold the sender until every predicted word is out, then let the block settle
    task automatic drain_words();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(cfg_idx_t idx, byte_t v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        tracker.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic program_regs(byte_t h, byte_t m1, byte_t m2);
        put_reg(CFG_HEADER_BYTE, h);
        put_reg(CFG_MARKER_FIRST, m1);
        put_reg(CFG_MARKER_SECOND, m2);
        put_reg(CFG_UNUSED, byte_t'($urandom));
        cfg_we <= 1'b0;
        cur_h = h;
        cur_m1 = m1;
        cur_m2 = m2;
    endtask

    task automatic send_frame(byte_t h, byte_t m1, byte_t m2, byte_t key, fill_t fm,
                              int length);
        byte_t f[FRAME_LEN];
        for (int i = 0; i < FRAME_LEN; i++)
            f[i] = (fm == FILL_ZERO) ? 8'h00 : (fm == FILL_ONES) ? 8'hFF : byte_t'($urandom);
        f[0] = h;
        f[KEY_OFS] = key;
        f[MARK1_OFS] = m1;
        f[MARK2_OFS] = m2;
        for (int i = 0; i < length; i++)
            send_byte(f[i]);
    endtask

    function automatic byte_t flip_bit(byte_t v);
        return v ^ byte_t'(1 << $urandom_range(0, 7));
    endfunction

    initial
    begin
        int    rand_start;
        int    words_start;
        int    phase_end;
        int    phase;
        int    pick;
        byte_t key;

        tracker = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_HEADER_BYTE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        bytes_sent = 0;
        gap_pct = 0;
        calm = 1'b0;
        cur_h = HEADER_BYTE_RST;
        cur_m1 = MARKER_FIRST_RST;
        cur_m2 = MARKER_SECOND_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, extreme keys, payloads and register values
        send_frame(cur_h, cur_m1, cur_m2, 8'hFF, FILL_ZERO, FRAME_LEN);
        drain_words();
        program_regs(8'hFF, 8'hFF, 8'hFF);
        send_frame(cur_h, cur_m1, cur_m2, 8'h00, FILL_ONES, FRAME_LEN);

        // random: mostly well-formed frames, some noise and broken frames
        rand_start = bytes_sent;
        words_start = tracker.words_predicted;
        phase = 0;
        while (bytes_sent - rand_start < RAND_BYTES ||
               tracker.words_predicted - words_start < RAND_WORDS)
        begin
            drain_words();
            case (phase % 5)
                0: program_regs(HEADER_BYTE_RST, MARKER_FIRST_RST, MARKER_SECOND_RST);
                1: program_regs(8'h00, 8'hFF, 8'h00);
                2: program_regs(8'hFF, 8'h00, 8'hFF);
                default: program_regs(byte_t'($urandom), byte_t'($urandom),
                                      byte_t'($urandom));
            endcase
            pick = $urandom_range(0, 2);
            gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                calm = (bytes_sent - rand_start >= CALM_AFTER);
                pick = $urandom_range(0, 99);
                key = ($urandom_range(0, 7) == 0) ? byte_t'({8{$urandom_range(0, 1) == 1}})
                                                  : byte_t'($urandom);
                if (pick < 65)
                    send_frame(cur_h, cur_m1, cur_m2, key, FILL_RANDOM, FRAME_LEN);
                else if (pick < 80)
                    repeat ($urandom_range(1, 20)) send_byte(byte_t'($urandom));
                else if (pick < 90)
                    send_frame(cur_h, cur_m1, cur_m2, key, FILL_RANDOM,
                               $urandom_range(1, FRAME_LEN - 1));
                else
                begin
                    case ($urandom_range(0, 2))
                        0: send_frame(flip_bit(cur_h), cur_m1, cur_m2, key, FILL_RANDOM,
                                      FRAME_LEN);
                        1: send_frame(cur_h, flip_bit(cur_m1), cur_m2, key, FILL_RANDOM,
                                      FRAME_LEN);
                        default: send_frame(cur_h, cur_m1, flip_bit(cur_m2), key,
                                            FILL_RANDOM, FRAME_LEN);
                    endcase
                end
            end
            phase++;
        end

        calm = 1'b1;
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
